// ----- hdl/ufsm_pkg.sv -----
package ufsm_pkg;

  // Width of one parent value and of the element/value fields.
  localparam int VAL_W = 10;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP1,
    ST_WRAP2,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Table write selection.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SPLICE1,
    WR_SPLICE2,
    WR_LOAD
  } wr_t;

  // Result register source.
  typedef enum logic [1:0] {
    RES_HOLD,
    RES_P1,
    RES_P2,
    RES_LOADV
  } res_t;

  typedef struct packed {
    logic take_in;
    logic adv1;
    logic adv2;
    logic cur_ld;
    wr_t  wr;
    res_t res;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_merge;
    logic p_eq;
    logic p1_lt;
    logic root1;
    logic root2;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/ufsm_ram.sv -----
module ufsm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ufsm_ctrl.sv -----
module ufsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ufsm_pkg::sts_t  sts,
  output ufsm_pkg::cmd_t  cmd,
  output ufsm_pkg::state_t state
);

  import ufsm_pkg::*;

  state_t state_next;
  logic   walk_end;

  // The spliced cursor was a root, or both parents already agree.
  assign walk_end = sts.p_eq || (sts.p1_lt && sts.root1) || (!sts.p1_lt && sts.root2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_WRAP1;
        end
      end
      ST_WRAP1: state_next = ST_WRAP2;
      ST_WRAP2: state_next = sts.is_merge ? ST_READ : ST_WRITE;
      ST_READ:  state_next = ST_CMP;
      ST_CMP:   state_next = walk_end ? ST_DONE : ST_WRAP1;
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wr = WR_NONE;
    cmd.res = RES_HOLD;
    case (state)
      ST_IDLE: begin
        cmd.take_in = in_valid;
      end
      ST_WRAP2: begin
        cmd.cur_ld = 1'b1;
      end
      ST_CMP: begin
        if (sts.p_eq) begin
          cmd.res = RES_P1;
        end else if (sts.p1_lt) begin
          cmd.wr = WR_SPLICE1;
          if (sts.root1) begin
            cmd.res = RES_P2;
          end else begin
            cmd.adv1 = 1'b1;
          end
        end else begin
          cmd.wr = WR_SPLICE2;
          if (sts.root2) begin
            cmd.res = RES_P1;
          end else begin
            cmd.adv2 = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        cmd.wr = WR_LOAD;
        cmd.res = RES_LOADV;
      end
      ST_DONE: begin
        cmd.out_ld = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/ufsm_dp.sv -----
module ufsm_dp #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mode,
  input  ufsm_pkg::val_t elem_a,
  input  ufsm_pkg::val_t elem_b,
  input  ufsm_pkg::cmd_t cmd,
  output ufsm_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output ufsm_pkg::val_t joined_parent
);

  import ufsm_pkg::*;

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int CMP_W = (IDX_W > VAL_W) ? IDX_W : VAL_W;
  localparam bit IS_POW2 = ((NUM_ELEMENTS & (NUM_ELEMENTS - 1)) == 0);
  localparam bit USE_RECIP = !IS_POW2 && (NUM_ELEMENTS < (2 ** VAL_W));
  // floor(v * RECIP_M / 2^RECIP_S) == floor(v / N) for every 10-bit v
  localparam int RECIP_S = 20;
  localparam logic [RECIP_S-1:0] RECIP_M =
    RECIP_S'(USE_RECIP ? ((2 ** RECIP_S) + NUM_ELEMENTS - 1) / NUM_ELEMENTS : 0);
  localparam logic [VAL_W-1:0] MOD_N = VAL_W'(USE_RECIP ? NUM_ELEMENTS : 0);

  // Unwrapped cursor values; cursor k is loaded with wv[k] mod N in the wrap step.
  val_t             wv [2];
  logic [IDX_W-1:0] wrapped [2];
  logic [IDX_W-1:0] cur [2];
  val_t             p1;
  val_t             p2;
  val_t             res;
  logic             merge_op;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  val_t             ram_wdata;

  for (genvar i = 0; i < 2; i++) begin : g_lane
    if (USE_RECIP) begin : g_recip
      logic [VAL_W+RECIP_S-1:0] prod;
      logic [2*VAL_W-1:0]       qn;
      val_t                     quo;
      val_t                     rem;

      assign prod = {{RECIP_S{1'b0}}, wv[i]} * {{VAL_W{1'b0}}, RECIP_M};

      always_ff @(posedge clk) begin
        quo <= prod[VAL_W+RECIP_S-1:RECIP_S];
      end

      assign qn = {{VAL_W{1'b0}}, quo} * {{VAL_W{1'b0}}, MOD_N};
      assign rem = wv[i] - qn[VAL_W-1:0];
      assign wrapped[i] = rem[IDX_W-1:0];
    end else if (IDX_W <= VAL_W) begin : g_mask
      assign wrapped[i] = wv[i][IDX_W-1:0];
    end else begin : g_ext
      assign wrapped[i] = {{(IDX_W-VAL_W){1'b0}}, wv[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      wv[0]    <= elem_a;
      wv[1]    <= elem_b;
      merge_op <= mode;
    end
    if (cmd.adv1) begin
      wv[0] <= p1;
    end
    if (cmd.adv2) begin
      wv[1] <= p2;
    end
    if (cmd.cur_ld) begin
      cur[0] <= wrapped[0];
      cur[1] <= wrapped[1];
    end
  end

  always_comb begin
    ram_we    = (cmd.wr != WR_NONE);
    ram_waddr = (cmd.wr == WR_SPLICE2) ? cur[1] : cur[0];
    case (cmd.wr)
      WR_SPLICE1: ram_wdata = p2;
      WR_SPLICE2: ram_wdata = p1;
      WR_LOAD:    ram_wdata = wv[1];
      default:    ram_wdata = p2;
    endcase
  end

  // Two copies of the table, written together, one read port each.
  ufsm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_ram1 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur[0]),
    .rdata (p1)
  );

  ufsm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_ram2 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur[1]),
    .rdata (p2)
  );

  assign sts.is_merge = merge_op;
  assign sts.p_eq     = (p1 == p2);
  assign sts.p1_lt    = (p1 < p2);
  assign sts.root1    = (CMP_W'(p1) == CMP_W'(cur[0]));
  assign sts.root2    = (CMP_W'(p2) == CMP_W'(cur[1]));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_P1:    res <= p1;
      RES_P2:    res <= p2;
      RES_LOADV: res <= wv[1];
      default:   res <= res;
    endcase
    if (cmd.out_ld) begin
      joined_parent <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/union_find_splice_merge.sv -----
// Sequence: a load word passes wrap, table write and done before the output
//   register; a merge word repeats walk steps until the walk ends.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result is registered. Each walk step is bound by the table read (read,
//   compare/splice, cursor wrap).
// Reset (rst, synchronous, active high) idles the controller and empties the
//   output register; the parent table is not cleared.
module union_find_splice_merge #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           mode,
  input  ufsm_pkg::val_t elem_a,
  input  ufsm_pkg::val_t elem_b,
  output logic           out_valid,
  input  logic           out_stall,
  output ufsm_pkg::val_t joined_parent
);

  import ufsm_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  // Input words are taken only in idle; the output register sits between
  // the walk and the consumer, so a finished word waits there while the
  // next input word is accepted and walked.
  assign in_stall = (state != ST_IDLE);

  // Controller: sequences wrap, read, compare/splice, load write and result hand-off.
  ufsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // Datapath: cursors, modulo wrap, duplicated parent table, result regs.
  ufsm_dp #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .elem_a        (elem_a),
    .elem_b        (elem_b),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .joined_parent (joined_parent)
  );

  // An accepted word blocks further input until its result is handed to the output register.
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // The table is written only while splicing or loading.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr != WR_NONE) |-> (state == ST_CMP || state == ST_WRITE))
    else $error("table write outside splice or load");

  // A read is always followed by the compare step.
  a_read_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_CMP))
    else $error("read not followed by compare");

  // A finished word reaches the output register and the block goes idle.
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && sts.out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not handed to output");

endmodule
